### rtl/csv_tok_pkg.sv
// Shared types and constants for the CSV row tokenizer.
// No dependencies; used by csv_tok_parse, csv_tok_outq and csv_row_tokenizer.
`timescale 1ns / 1ps
`default_nettype none

package csv_tok_pkg;

  localparam int unsigned MaxRes = 3;

  typedef enum logic [1:0] {
    KIND_VALUE = 2'd0,
    KIND_FIELD = 2'd1,
    KIND_ROW   = 2'd2
  } kind_e;

  localparam logic [7:0] ChNul    = 8'h00;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChDquote = 8'h22;
  localparam logic [7:0] ChSquote = 8'h27;
  localparam logic [7:0] ChBomEf  = 8'hEF;
  localparam logic [7:0] ChBomBb  = 8'hBB;
  localparam logic [7:0] ChBomBf  = 8'hBF;
  localparam logic [7:0] ChBomFe  = 8'hFE;
  localparam logic [7:0] ChBomFf  = 8'hFF;

  localparam logic [1:0] FmtNone  = 2'd0;
  localparam logic [1:0] FmtUtf8  = 2'd1;
  localparam logic [1:0] FmtU16Be = 2'd2;
  localparam logic [1:0] FmtU16Le = 2'd3;

  // Results caused by one input byte.
  typedef struct packed {
    logic [1:0]                cnt;
    logic [MaxRes-1:0][1:0]    kind;
    logic [MaxRes-1:0][7:0]    data;
    logic [1:0]                fmt;
  } grp_t;

endpackage

`default_nettype wire

### rtl/csv_tok_parse.sv
// Parser state and per-byte transition logic of the CSV row tokenizer.
// Depends on csv_tok_pkg.
`timescale 1ns / 1ps
`default_nettype none

module csv_tok_parse (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire logic [7:0]        in_byte_i,
  input  wire logic [7:0]        delimiter_i,
  output csv_tok_pkg::grp_t      grp_o
);

  typedef enum logic [2:0] {
    P_START  = 3'd0,
    P_SQUOTE = 3'd1,
    P_DQUOTE = 3'd2,
    P_PLAIN  = 3'd3,
    P_AFTER  = 3'd4,
    P_CR     = 3'd5,
    P_LF     = 3'd6,
    P_DQEND  = 3'd7
  } parse_e;

  typedef enum logic [2:0] {
    M_IDLE  = 3'd0,
    M_CHECK = 3'd1,
    M_EF    = 3'd2,
    M_EFBB  = 3'd3,
    M_FE    = 3'd4,
    M_FF    = 3'd5,
    M_SKIP  = 3'd6
  } mark_e;

  parse_e     parse_q, parse_d;
  mark_e      mark_q, mark_d;
  logic       rhf_q, rhf_d;
  logic [1:0] fmt_q, fmt_d;

  always_comb begin
    logic [7:0] c;
    logic [7:0] pair;
    logic       done;
    logic       skip;
    logic       eol;
    logic [1:0] n;
    logic [csv_tok_pkg::MaxRes-1:0][1:0] kind;
    logic [csv_tok_pkg::MaxRes-1:0][7:0] data;

    c       = in_byte_i;
    parse_d = parse_q;
    mark_d  = mark_q;
    rhf_d   = rhf_q;
    fmt_d   = fmt_q;
    done    = 1'b0;
    skip    = 1'b0;
    n       = 2'd0;
    kind    = '0;
    data    = '0;
    eol     = (c == csv_tok_pkg::ChCr) || (c == csv_tok_pkg::ChLf);
    pair    = (parse_q == P_CR) ? csv_tok_pkg::ChLf : csv_tok_pkg::ChCr;

    // Second byte of a CRLF / LFCR pair is swallowed.
    if (parse_q == P_CR || parse_q == P_LF) begin
      parse_d = P_START;
      mark_d  = M_CHECK;
      rhf_d   = 1'b0;
      if (c == csv_tok_pkg::ChNul || c == pair) done = 1'b1;
    end

    // End of data
    if (!done && c == csv_tok_pkg::ChNul) begin
      if (mark_d == M_IDLE) begin
        if ((parse_d == P_START && rhf_d) ||
            (parse_d != P_START && parse_d != P_AFTER)) begin
          kind[n] = csv_tok_pkg::KIND_FIELD;
          n = n + 2'd1;
        end
        kind[n] = csv_tok_pkg::KIND_ROW;
        n = n + 2'd1;
      end
      parse_d = P_START;
      mark_d  = M_CHECK;
      rhf_d   = 1'b0;
      done    = 1'b1;
    end

    // Byte order mark check
    if (!done) begin
      case (mark_d)
        M_CHECK: begin
          if (c == csv_tok_pkg::ChBomEf) begin
            mark_d = M_EF;
            done = 1'b1;
          end else if (c == csv_tok_pkg::ChBomFe) begin
            mark_d = M_FE;
            done = 1'b1;
          end else if (c == csv_tok_pkg::ChBomFf) begin
            mark_d = M_FF;
            done = 1'b1;
          end else begin
            mark_d = M_IDLE;
          end
        end
        M_EF: begin
          if (c == csv_tok_pkg::ChBomBb) begin
            mark_d = M_EFBB;
            done = 1'b1;
          end else begin
            skip = 1'b1;
          end
        end
        M_EFBB: begin
          if (c == csv_tok_pkg::ChBomBf) begin
            fmt_d = csv_tok_pkg::FmtUtf8;
            mark_d = M_IDLE;
            done = 1'b1;
          end else begin
            skip = 1'b1;
          end
        end
        M_FE: begin
          if (c == csv_tok_pkg::ChBomFf) begin
            fmt_d = csv_tok_pkg::FmtU16Be;
            mark_d = M_IDLE;
            done = 1'b1;
          end else begin
            skip = 1'b1;
          end
        end
        M_FF: begin
          if (c == csv_tok_pkg::ChBomFe) begin
            fmt_d = csv_tok_pkg::FmtU16Le;
            mark_d = M_IDLE;
            done = 1'b1;
          end else begin
            skip = 1'b1;
          end
        end
        M_SKIP: skip = 1'b1;
        default: mark_d = M_IDLE;
      endcase
      // Malformed mark: drop bytes up to the next double quote.
      if (!done && skip) begin
        if (c != csv_tok_pkg::ChDquote) begin
          mark_d = M_SKIP;
          done = 1'b1;
        end else begin
          mark_d = M_IDLE;
        end
      end
    end

    if (!done) begin
      case (parse_d)
        P_START: begin
          if (c == delimiter_i) begin
            kind[n] = csv_tok_pkg::KIND_FIELD;
            n = n + 2'd1;
            rhf_d = 1'b1;
          end else if (c == csv_tok_pkg::ChSpace || c == csv_tok_pkg::ChTab) begin
            parse_d = P_START;
          end else if (eol) begin
            if (rhf_d) begin
              kind[n] = csv_tok_pkg::KIND_FIELD;
              n = n + 2'd1;
            end
            kind[n] = csv_tok_pkg::KIND_ROW;
            n = n + 2'd1;
            parse_d = (c == csv_tok_pkg::ChCr) ? P_CR : P_LF;
            mark_d = M_IDLE;
            rhf_d = 1'b0;
          end else if (c == csv_tok_pkg::ChSquote) begin
            parse_d = P_SQUOTE;
          end else if (c == csv_tok_pkg::ChDquote) begin
            parse_d = P_DQUOTE;
          end else begin
            kind[n] = csv_tok_pkg::KIND_VALUE;
            data[n] = c;
            n = n + 2'd1;
            parse_d = P_PLAIN;
          end
        end
        P_SQUOTE: begin
          if (c == csv_tok_pkg::ChSquote) begin
            kind[n] = csv_tok_pkg::KIND_FIELD;
            n = n + 2'd1;
            rhf_d = 1'b1;
            parse_d = P_AFTER;
          end else begin
            kind[n] = csv_tok_pkg::KIND_VALUE;
            data[n] = c;
            n = n + 2'd1;
          end
        end
        P_DQUOTE: begin
          if (c == csv_tok_pkg::ChDquote) begin
            parse_d = P_DQEND;
          end else begin
            kind[n] = csv_tok_pkg::KIND_VALUE;
            data[n] = c;
            n = n + 2'd1;
          end
        end
        P_DQEND: begin
          if (c == delimiter_i) begin
            kind[n] = csv_tok_pkg::KIND_FIELD;
            n = n + 2'd1;
            rhf_d = 1'b1;
            parse_d = P_START;
          end else if (c == csv_tok_pkg::ChDquote) begin
            // doubled quote inside a quoted value
            kind[n] = csv_tok_pkg::KIND_VALUE;
            data[n] = csv_tok_pkg::ChDquote;
            n = n + 2'd1;
            parse_d = P_DQUOTE;
          end else if (eol) begin
            kind[n] = csv_tok_pkg::KIND_FIELD;
            n = n + 2'd1;
            kind[n] = csv_tok_pkg::KIND_ROW;
            n = n + 2'd1;
            parse_d = (c == csv_tok_pkg::ChCr) ? P_CR : P_LF;
            mark_d = M_IDLE;
            rhf_d = 1'b0;
          end else begin
            kind[n] = csv_tok_pkg::KIND_FIELD;
            n = n + 2'd1;
            rhf_d = 1'b1;
            parse_d = P_AFTER;
          end
        end
        P_AFTER: begin
          if (c == delimiter_i) begin
            parse_d = P_START;
          end else if (eol) begin
            kind[n] = csv_tok_pkg::KIND_ROW;
            n = n + 2'd1;
            parse_d = (c == csv_tok_pkg::ChCr) ? P_CR : P_LF;
            mark_d = M_IDLE;
            rhf_d = 1'b0;
          end
        end
        P_PLAIN: begin
          if (c == delimiter_i) begin
            kind[n] = csv_tok_pkg::KIND_FIELD;
            n = n + 2'd1;
            rhf_d = 1'b1;
            parse_d = P_START;
          end else if (eol) begin
            kind[n] = csv_tok_pkg::KIND_FIELD;
            n = n + 2'd1;
            kind[n] = csv_tok_pkg::KIND_ROW;
            n = n + 2'd1;
            parse_d = (c == csv_tok_pkg::ChCr) ? P_CR : P_LF;
            mark_d = M_IDLE;
            rhf_d = 1'b0;
          end else begin
            kind[n] = csv_tok_pkg::KIND_VALUE;
            data[n] = c;
            n = n + 2'd1;
          end
        end
        default: parse_d = P_START;
      endcase
    end

    grp_o.cnt  = n;
    grp_o.kind = kind;
    grp_o.data = data;
    grp_o.fmt  = fmt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parse_q <= P_START;
      mark_q  <= M_CHECK;
      rhf_q   <= 1'b0;
      fmt_q   <= csv_tok_pkg::FmtNone;
    end else if (accept_i) begin
      parse_q <= parse_d;
      mark_q  <= mark_d;
      rhf_q   <= rhf_d;
      fmt_q   <= fmt_d;
    end
  end

endmodule

`default_nettype wire

### rtl/csv_tok_outq.sv
// Result register of the CSV row tokenizer: holds the results of one byte
// and hands them out one per transaction. Depends on csv_tok_pkg.
`timescale 1ns / 1ps
`default_nettype none

module csv_tok_outq (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              load_i,
  input  wire csv_tok_pkg::grp_t grp_i,
  output logic                   free_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [1:0]             kind_o,
  output logic [7:0]             value_byte_o,
  output logic [1:0]             format_o,
  output logic                   last_o
);

  logic [1:0] rem_q, rem_d;
  logic [1:0] ptr_q, ptr_d;
  logic [csv_tok_pkg::MaxRes-1:0][1:0] kind_q;
  logic [csv_tok_pkg::MaxRes-1:0][7:0] data_q;
  logic [1:0] fmt_q;
  logic       pop;

  assign out_valid_o = (rem_q != 2'd0);
  assign pop         = out_valid_o && !out_stall_i;
  assign free_o      = (rem_q == 2'd0) || (rem_q == 2'd1 && pop);
  assign last_o      = (rem_q == 2'd1);
  assign kind_o      = kind_q[ptr_q];
  assign value_byte_o = data_q[ptr_q];
  assign format_o    = fmt_q;

  always_comb begin
    rem_d = rem_q;
    ptr_d = ptr_q;
    if (load_i) begin
      rem_d = grp_i.cnt;
      ptr_d = 2'd0;
    end else if (pop) begin
      rem_d = rem_q - 2'd1;
      ptr_d = ptr_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= 2'd0;
      ptr_q <= 2'd0;
    end else begin
      rem_q <= rem_d;
      ptr_q <= ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      kind_q <= grp_i.kind;
      data_q <= grp_i.data;
      fmt_q  <= grp_i.fmt;
    end
  end

endmodule

`default_nettype wire

### rtl/csv_row_tokenizer.sv
// Top level of the CSV row tokenizer: parser plus result register.
// Depends on csv_tok_pkg, csv_tok_parse and csv_tok_outq.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_byte_i) takes one text byte
//   per transaction; byte 0 marks end of data. Output channel (out_valid_o /
//   out_stall_i) gives one token per transaction: kind_o (value byte, end of
//   field, end of row), value_byte_o, format_o and last_o, which flags the
//   final token caused by an input byte. A byte may cause zero to two
//   tokens.
//   Latency: tokens of a byte appear the cycle after it is accepted.
//   Throughput: one byte per cycle while each byte gives at most one token
//   and the receiver does not stall; a byte giving more tokens holds the
//   result register until its last token leaves, the cycle the next byte
//   is taken. Bytes giving no token never wait once the register is free.
//   delimiter_we_i / delimiter_i load the field delimiter (reset: comma);
//   write it only while the block is idle.
//   Reset: parser at row start checking for a byte order mark, no format,
//   no pending tokens. A receiver stall holds the current token and stalls
//   the input side while any token is pending.
`timescale 1ns / 1ps
`default_nettype none

module csv_row_tokenizer (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] in_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [1:0]      kind_o,
  output logic [7:0]      value_byte_o,
  output logic [1:0]      format_o,
  output logic            last_o,
  input  wire logic       delimiter_we_i,
  input  wire logic [7:0] delimiter_i
);

  logic [7:0]         delim_q;
  logic               free;
  logic               accept;
  csv_tok_pkg::grp_t  grp;

  assign in_stall_o = !free;
  assign accept     = in_valid_i && free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_q <= 8'd44;
    end else if (delimiter_we_i) begin
      delim_q <= delimiter_i;
    end
  end

  csv_tok_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .in_byte_i   (in_byte_i),
    .delimiter_i (delim_q),
    .grp_o       (grp)
  );

  csv_tok_outq u_outq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (accept),
    .grp_i        (grp),
    .free_o       (free),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .kind_o       (kind_o),
    .value_byte_o (value_byte_o),
    .format_o     (format_o),
    .last_o       (last_o)
  );

endmodule

`default_nettype wire
